[hdl/sat_pkg.sv]
package sat_pkg;

  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int VAL_W   = 32;
  localparam int COORD_W = 8;
  localparam int SUM_W   = 64;

  localparam logic [CFG_W-1:0] GRID_DIM_RESET = CFG_W'(64);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_WR,
    ST_Q_RD0,
    ST_Q_RD1,
    ST_Q_FIN
  } sat_state_t;

endpackage

[hdl/summed_area_table_top.sv]
// Summed-area table (2-D prefix sum) over a grid of up to MAX_ROWS x MAX_COLS
// signed 32-bit elements, kept as 64-bit prefix entries in one synchronous
// RAM with one write port and two read ports. A load word (opcode 0) brings
// the next element in row-major order; it first reads the prefix entry above
// and then writes the new entry (running row sum plus that entry). Loads past
// the end of the grid are dropped. A query word (opcode 1) asks for the sum
// over [row_begin,row_end) x [col_begin,col_end), each bound clamped to the
// configured height or width as capped at the table size; it latches the
// clamped bounds, fetches the four corners two at a time through the two RAM
// read ports, and combines them, after which the answer sits in the output
// register. An inverted rectangle answers zero. Sums wrap modulo 2^64. The
// block handles one word at a time; a finished answer waiting in the output
// register does not hold up the next word until a second answer is ready.
// Writing grid_height (index 0) or grid_width (index 1) restarts loading at
// the first element and keeps the table contents. Queries must only be issued
// after the whole grid has been loaded; entries never written read as garbage.
module summed_area_table_top
  import sat_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic signed [VAL_W-1:0]   in_element_value,
  input  logic [COORD_W-1:0]        in_row_begin,
  input  logic [COORD_W-1:0]        in_row_end,
  input  logic [COORD_W-1:0]        in_col_begin,
  input  logic [COORD_W-1:0]        in_col_end,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SUM_W-1:0]   out_rect_sum,

  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Row and column counts range over 0..MAX, so they carry one extra value.
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  // Common widths for comparing register and coordinate values to the limits.
  localparam int RHW   = (RW > COORD_W) ? RW : COORD_W;
  localparam int CHW   = (CW > COORD_W) ? CW : COORD_W;

  // Configuration and effective grid size.
  logic [CFG_W-1:0] grid_height_r;
  logic [CFG_W-1:0] grid_width_r;
  logic [RW-1:0]    eff_h;
  logic [CW-1:0]    eff_w;

  // Load position and running sum of the current row.
  logic [RW-1:0]    load_row_r;
  logic [CW-1:0]    load_col_r;
  logic [SUM_W-1:0] run_sum_r;

  // Clamped query bounds.
  logic [RW-1:0]    y1_r, y2_r;
  logic [CW-1:0]    x1_r, x2_r;
  logic             inv_r;
  logic [RW-1:0]    y1_c, y2_c;
  logic [CW-1:0]    x1_c, x2_c;

  logic [SUM_W-1:0] partial_r;
  logic             out_valid_r;
  logic [SUM_W-1:0] out_rect_sum_r;

  sat_state_t       state_r, state_nxt;

  logic             in_acc;
  logic             load_ok;
  logic             rd_en, wr_en, out_load;
  logic [AW-1:0]    rd_addr0, rd_addr1, wr_addr;
  logic [SUM_W-1:0] rd_data0, rd_data1, wr_data;
  logic             zf0, zf1, zf0_r, zf1_r;
  logic [SUM_W-1:0] corner0, corner1;
  logic [SUM_W-1:0] result;

  function automatic logic [AW-1:0] entry_addr(input logic [RW-1:0] r,
                                               input logic [CW-1:0] c);
    logic [AW-1:0] row_base;
    row_base   = AW'(AW'(r) * AW'(MAX_COLS));
    entry_addr = row_base + AW'(c);
  endfunction

  // Effective height and width: the register value capped at the table size.
  always_comb begin
    if (RHW'(grid_height_r) < RHW'(MAX_ROWS)) begin
      eff_h = RW'(grid_height_r);
    end else begin
      eff_h = RW'(MAX_ROWS);
    end
    if (CHW'(grid_width_r) < CHW'(MAX_COLS)) begin
      eff_w = CW'(grid_width_r);
    end else begin
      eff_w = CW'(MAX_COLS);
    end
  end

  // Clamp each query bound to the effective grid size.
  always_comb begin
    y1_c = (RHW'(in_row_begin) < RHW'(eff_h)) ? RW'(in_row_begin) : eff_h;
    y2_c = (RHW'(in_row_end)   < RHW'(eff_h)) ? RW'(in_row_end)   : eff_h;
    x1_c = (CHW'(in_col_begin) < CHW'(eff_w)) ? CW'(in_col_begin) : eff_w;
    x2_c = (CHW'(in_col_end)   < CHW'(eff_w)) ? CW'(in_col_end)   : eff_w;
  end

  assign in_acc  = in_valid && !in_stall;
  assign load_ok = (load_row_r < eff_h) && (load_col_r < eff_w);
  assign in_stall = (state_r != ST_IDLE);

  // Corner values; row zero and column zero of the table read as zero.
  assign corner0 = zf0_r ? '0 : rd_data0;
  assign corner1 = zf1_r ? '0 : rd_data1;

  assign wr_addr = entry_addr(load_row_r, load_col_r);
  assign wr_data = run_sum_r + corner0;
  assign result  = inv_r ? '0 : (partial_r - corner0 + corner1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer. A load reads the entry above in the accept cycle and writes
  // the new entry in the next one. A query fetches corners (y2,x2),(y1,x2)
  // and then (y2,x1),(y1,x1), one pair per cycle.
  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    out_load  = 1'b0;
    rd_addr0  = entry_addr(load_row_r - RW'(1), load_col_r);
    rd_addr1  = '0;
    zf0       = (load_row_r == '0);
    zf1       = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_QUERY) begin
            state_nxt = ST_Q_RD0;
          end else if (load_ok) begin
            rd_en     = 1'b1;
            state_nxt = ST_LD_WR;
          end
        end
      end
      ST_LD_WR: begin
        wr_en     = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_Q_RD0: begin
        rd_en     = 1'b1;
        rd_addr0  = entry_addr(y2_r - RW'(1), x2_r - CW'(1));
        rd_addr1  = entry_addr(y1_r - RW'(1), x2_r - CW'(1));
        zf0       = (y2_r == '0) || (x2_r == '0);
        zf1       = (y1_r == '0) || (x2_r == '0);
        state_nxt = ST_Q_RD1;
      end
      ST_Q_RD1: begin
        rd_en     = 1'b1;
        rd_addr0  = entry_addr(y2_r - RW'(1), x1_r - CW'(1));
        rd_addr1  = entry_addr(y1_r - RW'(1), x1_r - CW'(1));
        zf0       = (y2_r == '0) || (x1_r == '0);
        zf1       = (y1_r == '0) || (x1_r == '0);
        state_nxt = ST_Q_FIN;
      end
      ST_Q_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  sat_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  // The zero flags are registered with the read data, under the same read enable.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      zf0_r <= zf0;
      zf1_r <= zf1;
    end
  end

  // Configuration, load position and running row sum. A register write
  // restarts loading at the first element of the grid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_height_r <= GRID_DIM_RESET;
      grid_width_r  <= GRID_DIM_RESET;
      load_row_r    <= '0;
      load_col_r    <= '0;
      run_sum_r     <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_GRID_HEIGHT) begin
        grid_height_r <= cfg_wdata;
      end else begin
        grid_width_r  <= cfg_wdata;
      end
      load_row_r <= '0;
      load_col_r <= '0;
      run_sum_r  <= '0;
    end else if (state_r == ST_IDLE && in_acc && in_opcode == OP_LOAD && load_ok) begin
      run_sum_r <= run_sum_r + {{(SUM_W-VAL_W){in_element_value[VAL_W-1]}},
                                in_element_value};
    end else if (state_r == ST_LD_WR) begin
      if (load_col_r + CW'(1) >= eff_w) begin
        load_col_r <= '0;
        load_row_r <= load_row_r + RW'(1);
        run_sum_r  <= '0;
      end else begin
        load_col_r <= load_col_r + CW'(1);
      end
    end
  end

  // Query datapath.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc && in_opcode == OP_QUERY) begin
      y1_r  <= y1_c;
      y2_r  <= y2_c;
      x1_r  <= x1_c;
      x2_r  <= x2_c;
      inv_r <= (y1_c > y2_c) || (x1_c > x2_c);
    end
    if (state_r == ST_Q_RD1) begin
      partial_r <= corner0 - corner1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rect_sum_r <= result;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_rect_sum = out_rect_sum_r;

`ifndef SYNTHESIS
  // A new answer only appears straight out of the final query step.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_Q_FIN))
    else $error("answer appeared outside the final query step");

  // An accepted query starts its corner fetch in the next cycle.
  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_opcode == OP_QUERY) |=> (state_r == ST_Q_RD0))
    else $error("accepted query did not start its corner fetch");

  // The load column never runs past the configured width.
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (load_col_r < eff_w) || (load_col_r == '0))
    else $error("load column beyond grid width");

  // A table write always follows a read of the entry above.
  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> $past(rd_en))
    else $error("table write without a preceding read");
`endif

endmodule

[hdl/sat_table.sv]
module sat_table
  import sat_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [SUM_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr0,
  input  logic [AW-1:0]    rd_addr1,
  output logic [SUM_W-1:0] rd_data0,
  output logic [SUM_W-1:0] rd_data1
);

  // Prefix entries, one write and two registered reads per cycle.
  logic [SUM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

[tb/sv/tb_summed_area_table_top.sv]
module tb_summed_area_table_top;
  import sat_pkg::*;

  // The block is built with its default table size; the checker keeps a table
  // of the same shape so that stale entries survive a change of width exactly
  // as they do in the RAM.
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  // Cycles without any handshake before the run is declared hung. The slowest
  // legal stretch is the long output hold plus a few bursts, well below this.
  localparam int STALL_LIMIT = 2000;
  // Settling time that covers any word that was still in flight when the
  // last expected sum came out.
  localparam int SETTLE_CYCLES = 8;
  // Words that actually do something (effective loads and queries) to issue
  // in the random part.
  localparam int RANDOM_WORDS = 800;
  // Length of the deliberate output hold-off that backs the block up.
  localparam int LONG_HOLD = 400;
  // Largest grid area used in the random part, to keep load phases short.
  localparam int MAX_AREA = 256;

  typedef struct {
    logic                    opcode;
    logic signed [VAL_W-1:0] value;
    logic [COORD_W-1:0]      row_begin;
    logic [COORD_W-1:0]      row_end;
    logic [COORD_W-1:0]      col_begin;
    logic [COORD_W-1:0]      col_end;
  } sat_word_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_opcode = OP_LOAD;
  logic signed [VAL_W-1:0] in_element_value = '0;
  logic [COORD_W-1:0]      in_row_begin = '0;
  logic [COORD_W-1:0]      in_row_end = '0;
  logic [COORD_W-1:0]      in_col_begin = '0;
  logic [COORD_W-1:0]      in_col_end = '0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SUM_W-1:0] out_rect_sum;

  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_GRID_HEIGHT;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  summed_area_table_top #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_element_value(in_element_value),
    .in_row_begin    (in_row_begin),
    .in_row_end      (in_row_end),
    .in_col_begin    (in_col_begin),
    .in_col_end      (in_col_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rect_sum    (out_rect_sum),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prefix-sum predictor. It mirrors the block's registers, its table and its
  // load cursor, and is advanced once for every word the block accepts.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] prefix_mem [MAX_ROWS*MAX_COLS];
  logic [SUM_W-1:0] row_acc = '0;
  int               load_r = 0;
  int               load_c = 0;
  logic [CFG_W-1:0] height_reg = GRID_DIM_RESET;
  logic [CFG_W-1:0] width_reg = GRID_DIM_RESET;

  // Rectangle sums owed by the block, oldest first.
  logic [SUM_W-1:0] sums_due [$];

  // Stimulus side: words waiting for the driver, and a picture of which table
  // entries will have been written by the time each queued word is reached.
  // Queries are only built so that every corner they touch is already written.
  sat_word_t        pending [$];
  bit               filled [MAX_ROWS*MAX_COLS];
  int               gen_h = MAX_ROWS;
  int               gen_w = MAX_COLS;
  int               gen_r = 0;
  int               gen_c = 0;
  int               live_words = 0;

  // Driver state: the word on offer and the length of the current gap.
  sat_word_t        cur_word;
  bit               word_held = 1'b0;
  int               gap_left = 0;

  // Shared knobs for the two handshake processes.
  int               idle_odds = 0;
  bit               final_part = 1'b0;
  int               errors = 0;

  function automatic int clamp_to(int v, int lim);
    return (v < lim) ? v : lim;
  endfunction

  // Prefix entry P(r,c); the top row and the left column are implicit zeros.
  function automatic logic [SUM_W-1:0] prefix_at(int r, int c);
    if (r == 0 || c == 0) return '0;
    return prefix_mem[(r - 1) * MAX_COLS + (c - 1)];
  endfunction

  task automatic predict_word(sat_word_t word);
    int               h;
    int               wd;
    int               y1;
    int               y2;
    int               x1;
    int               x2;
    logic [SUM_W-1:0] ext;
    logic [SUM_W-1:0] acc;
    h  = clamp_to(int'(height_reg), MAX_ROWS);
    wd = clamp_to(int'(width_reg), MAX_COLS);
    if (word.opcode == OP_LOAD) begin
      // Loads beyond the end of the grid, or into an empty grid, are dropped.
      if (load_r < h && load_c < wd) begin
        ext = {{(SUM_W - VAL_W){word.value[VAL_W-1]}}, word.value};
        row_acc = row_acc + ext;
        prefix_mem[load_r * MAX_COLS + load_c] = row_acc + prefix_at(load_r, load_c + 1);
        load_c++;
        if (load_c >= wd) begin
          load_c = 0;
          row_acc = '0;
          load_r++;
        end
      end
    end else begin
      y1 = clamp_to(int'(word.row_begin), h);
      y2 = clamp_to(int'(word.row_end), h);
      x1 = clamp_to(int'(word.col_begin), wd);
      x2 = clamp_to(int'(word.col_end), wd);
      acc = '0;
      if (x1 <= x2 && y1 <= y2) begin
        acc = prefix_at(y2, x2) - prefix_at(y1, x2) - prefix_at(y2, x1) + prefix_at(y1, x1);
      end
      sums_due.push_back(acc);
    end
  endtask

  task automatic flag_error(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic bit cell_ok(int r, int c);
    return r == 0 || c == 0 || filled[(r - 1) * MAX_COLS + (c - 1)];
  endfunction

  function automatic bit corners_written(sat_word_t word);
    int y1;
    int y2;
    int x1;
    int x2;
    y1 = clamp_to(int'(word.row_begin), gen_h);
    y2 = clamp_to(int'(word.row_end), gen_h);
    x1 = clamp_to(int'(word.col_begin), gen_w);
    x2 = clamp_to(int'(word.col_end), gen_w);
    return cell_ok(y1, x1) && cell_ok(y1, x2) && cell_ok(y2, x1) && cell_ok(y2, x2);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(VAL_W - 1){1'b1}}};
      1:       return {1'b1, {(VAL_W - 1){1'b0}}};
      2:       return '1;
      3:       return '0;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Grid dimensions lean small, with the register extremes mixed in: zero,
  // one, the table size, and values past it that the block clamps.
  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CFG_W'($urandom_range(MAX_ROWS + 1, 127));
      2:       return '1;
      3:       return CFG_W'(MAX_ROWS);
      4:       return CFG_W'(1);
      default: return CFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic queue_load(logic signed [VAL_W-1:0] v);
    sat_word_t word;
    word.opcode    = OP_LOAD;
    word.value     = v;
    word.row_begin = COORD_W'($urandom);
    word.row_end   = COORD_W'($urandom);
    word.col_begin = COORD_W'($urandom);
    word.col_end   = COORD_W'($urandom);
    if (gen_r < gen_h && gen_c < gen_w) begin
      filled[gen_r * MAX_COLS + gen_c] = 1'b1;
      gen_c++;
      if (gen_c >= gen_w) begin
        gen_c = 0;
        gen_r++;
      end
      live_words++;
    end
    pending.push_back(word);
  endtask

  task automatic queue_query(logic [COORD_W-1:0] rb, logic [COORD_W-1:0] re,
                             logic [COORD_W-1:0] cb, logic [COORD_W-1:0] ce);
    sat_word_t word;
    word.opcode    = OP_QUERY;
    word.value     = VAL_W'($urandom);
    word.row_begin = rb;
    word.row_end   = re;
    word.col_begin = cb;
    word.col_end   = ce;
    // A rectangle that would touch a never-written entry collapses onto the
    // zero row instead, which keeps the column bounds random.
    if (!corners_written(word)) begin
      word.row_begin = '0;
      word.row_end   = '0;
    end
    pending.push_back(word);
    live_words++;
  endtask

  task automatic queue_random_query();
    int                 ready;
    int                 mode;
    logic [COORD_W-1:0] rb;
    logic [COORD_W-1:0] re;
    logic [COORD_W-1:0] cb;
    logic [COORD_W-1:0] ce;
    logic [COORD_W-1:0] t;
    ready = (gen_r < gen_h) ? gen_r : gen_h;
    mode  = $urandom_range(0, 9);
    if (mode < 2) begin
      // Full coordinate range: exercises clamping and every bound bit.
      rb = COORD_W'($urandom);
      re = COORD_W'($urandom);
      cb = COORD_W'($urandom);
      ce = COORD_W'($urandom);
    end else begin
      rb = COORD_W'($urandom_range(0, ready));
      re = COORD_W'($urandom_range(0, ready));
      cb = COORD_W'($urandom_range(0, gen_w));
      ce = COORD_W'($urandom_range(0, gen_w));
      // Most in-range rectangles are proper; the rest stay possibly inverted.
      if (mode < 8) begin
        if (rb > re) begin
          t = rb;
          rb = re;
          re = t;
        end
        if (cb > ce) begin
          t = cb;
          cb = ce;
          ce = t;
        end
      end
    end
    queue_query(rb, re, cb, ce);
  endtask

  // Waits until every queued word has been taken and every sum has come out,
  // then lets any trailing load finish inside the block.
  task automatic wait_drained();
    @(posedge clk);
    while (pending.size() != 0 || word_held || sums_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRID_HEIGHT: height_reg = val;
      CFG_GRID_WIDTH:  width_reg = val;
      default:         ;
    endcase
    // Any register write restarts loading at the first element; the table
    // itself keeps its contents.
    row_acc = '0;
    load_r  = 0;
    load_c  = 0;
    gen_h   = clamp_to(int'(height_reg), MAX_ROWS);
    gen_w   = clamp_to(int'(width_reg), MAX_COLS);
    gen_r   = 0;
    gen_c   = 0;
  endtask

  task automatic set_grid(logic [CFG_W-1:0] hv, logic [CFG_W-1:0] wv);
    wait_drained();
    write_reg(CFG_GRID_HEIGHT, hv);
    write_reg(CFG_GRID_WIDTH, wv);
  endtask

  // One configuration followed by a row-major load with queries sprinkled in.
  // A cut-short phase stops partway through the grid so that the next write
  // restarts loading over a partly loaded table.
  task automatic run_phase(logic [CFG_W-1:0] hv, logic [CFG_W-1:0] wv, bit cut_short,
                           int n_queries);
    int cells;
    int n_loads;
    int i;
    set_grid(hv, wv);
    case ($urandom_range(0, 3))
      0:       idle_odds = 0;
      1:       idle_odds = 3;
      2:       idle_odds = 6;
      default: idle_odds = 12;
    endcase
    if (final_part) begin
      idle_odds = 0;
    end
    cells   = gen_h * gen_w;
    n_loads = (cut_short && cells > 0) ? $urandom_range(0, cells - 1) : cells;
    for (i = 0; i < n_loads; i++) begin
      queue_load(pick_value());
      if ($urandom_range(0, 4) == 0) begin
        queue_random_query();
      end
    end
    if (!cut_short) begin
      // Now and then a few loads past the full grid, which must be dropped.
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) queue_load(pick_value());
      end
      repeat (n_queries) queue_random_query();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver. It takes words from the pending queue one at a time, holds each
  // one steady until the block accepts it, and feeds accepted words to the
  // predictor. Random gaps are only opened when no word is being offered, so
  // valid never drops while a word waits.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_word(cur_word);
        word_held = 1'b0;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          gap_left = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur_word         = pending.pop_front();
          word_held        = 1'b1;
          in_valid         <= 1'b1;
          in_opcode        <= cur_word.opcode;
          in_element_value <= cur_word.value;
          in_row_begin     <= cur_word.row_begin;
          in_row_end       <= cur_word.row_end;
          in_col_begin     <= cur_word.col_begin;
          in_col_end       <= cur_word.col_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every accepted result word is checked against the oldest sum
  // owed. The stall pattern mixes short random bursts with two long holds
  // that are started while plenty of words are still queued, so the block
  // backs up and has to stall its own input.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] want_sum;
  int               hold_left = 0;
  int               sums_seen = 0;
  int               long_holds = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        sums_seen++;
        if (sums_due.size() == 0) begin
          flag_error($sformatf("rect_sum %h arrived with no query outstanding", out_rect_sum));
        end else begin
          want_sum = sums_due.pop_front();
          if (out_rect_sum !== want_sum) begin
            flag_error($sformatf("rect_sum got %h, want %h", out_rect_sum, want_sum));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!final_part && long_holds < 2 && sums_seen >= 40 * (long_holds + 1) &&
                   pending.size() >= 8) begin
        hold_left = LONG_HOLD - 1;
        long_holds++;
        out_stall <= 1'b1;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        hold_left = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a run in which no word moves on either side for too long is hung.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
    end
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] hv;
    logic [CFG_W-1:0] wv;
    bit               cut;
    hv  = GRID_DIM_RESET;
    wv  = GRID_DIM_RESET;
    cut = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Straight out of reset, with the reset grid size: the load cursor must
    // start at the first entry, and a rectangle clamped onto column zero
    // reads only implicit zeros.
    queue_load(32'sd5);
    queue_query(0, 1, 0, 1);
    queue_query(255, 0, 0, 0);

    // A 2x3 grid with the signed extremes, then two loads past the end that
    // must be dropped, then the full, clamped, inner, inverted, empty and
    // single-cell rectangles.
    set_grid(CFG_W'(2), CFG_W'(3));
    queue_load({1'b0, {(VAL_W - 1){1'b1}}});
    queue_load({1'b1, {(VAL_W - 1){1'b0}}});
    queue_load('0);
    queue_load('1);
    queue_load(32'sd1);
    queue_load({1'b1, {(VAL_W - 1){1'b0}}});
    queue_load({1'b0, {(VAL_W - 1){1'b1}}});
    queue_load({1'b0, {(VAL_W - 1){1'b1}}});
    queue_query(0, 2, 0, 3);
    queue_query(0, 255, 0, 255);
    queue_query(1, 2, 1, 3);
    queue_query(2, 1, 0, 3);
    queue_query(0, 2, 3, 1);
    queue_query(1, 1, 0, 3);
    queue_query(1, 2, 2, 3);

    // Zero height, then zero width: loads are dropped and queries answer zero.
    set_grid('0, CFG_W'(3));
    queue_load('1);
    queue_query(0, 255, 0, 255);
    set_grid(CFG_W'(1), '0);
    queue_load('1);
    queue_query(0, 255, 0, 255);

    // Random phases. A phase after a cut-short one often keeps the same size,
    // so loading restarts over the entries just written.
    live_words = 0;
    while (live_words < RANDOM_WORDS) begin
      if (!(cut && $urandom_range(0, 1) == 0)) begin
        hv = pick_dim();
        wv = pick_dim();
        if (clamp_to(int'(hv), MAX_ROWS) * clamp_to(int'(wv), MAX_COLS) > MAX_AREA) begin
          wv = CFG_W'($urandom_range(1, 4));
        end
      end
      cut = ($urandom_range(0, 4) == 0);
      run_phase(hv, wv, cut, $urandom_range(4, 16));
    end

    // Closing phase at full rate on both sides.
    final_part = 1'b1;
    run_phase(CFG_W'(5), CFG_W'(7), 1'b0, 24);
    wait_drained();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[summed_area_table_top.f]
hdl/sat_pkg.sv
hdl/sat_table.sv
hdl/summed_area_table_top.sv
tb/sv/tb_summed_area_table_top.sv
